// File: rtl/kgsr_pkg.sv
// shared types and constants for the k-group stream reverser
package kgsr_pkg;

  localparam int MAX_GROUP_DEF = 16;
  localparam int VALUE_W       = 32;
  localparam int GSIZE_W       = 5;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [PADDR_W-1:0] ADDR_GROUP_SIZE = 3'd0;
  localparam logic [GSIZE_W-1:0] GSIZE_RESET     = 5'd1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } elem_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    logic                      run_end;
    logic                      list_end;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SHOW
  } state_t;

endpackage

// File: rtl/k_group_stream_reverser.sv
// k-group stream reverser: group buffer memory, fill counter and drain sequencer
// an item that closes a group moves the sequencer through ST_FETCH, where the first entry is read, to ST_SHOW
// a group of n results drains with one memory read per result, paced by res_ready
// items that do not close a group leave the sequencer in ST_IDLE; no item is taken while draining
// collecting and draining never overlap, so no new group is taken until the last one has drained
// reset: synchronous active-high rst empties the group and sets group_size to 1
// group buffer memory is not cleared; entries are always written before being read
module k_group_stream_reverser #(
  parameter int MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // element stream in
  input  logic                          elem_valid,
  output logic                          elem_ready,
  input  kgsr_pkg::elem_t               elem,
  // result stream out
  output logic                          res_valid,
  input  logic                          res_ready,
  output kgsr_pkg::res_t                res,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kgsr_pkg::PADDR_W-1:0]  paddr,
  input  logic [kgsr_pkg::PDATA_W-1:0]  pwdata,
  output logic [kgsr_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import kgsr_pkg::*;

  // address bits into the buffer, and count bits that can hold MAX_GROUP itself
  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW = $clog2(MAX_GROUP + 1);
  // compare width wide enough for both the count and the group size register
  localparam int KW = (CW > GSIZE_W) ? CW : GSIZE_W;

  // group buffer: one write port used while collecting, one read port while draining
  logic [VALUE_W-1:0] group_mem [MAX_GROUP];
  logic [VALUE_W-1:0] rd_data;

  // control state
  state_t             state, state_next;
  logic [CW-1:0]      fill;
  logic [GSIZE_W-1:0] group_size;

  // drain bookkeeping
  logic [CW-1:0]      rem;     // results still to deliver, including the one on show
  logic [AW-1:0]      idx;     // buffer entry of the result on show
  logic               rev;     // full group: walk the buffer downward
  logic               lst;     // this drain ends the sequence

  logic               elem_acc, res_acc, cfg_wr;
  logic [CW-1:0]      n;
  logic [KW-1:0]      k_eff;
  logic               flush_full, flush;
  logic               rd_en;
  logic [AW-1:0]      rd_addr, idx_step;
  logic               last_res;

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GSIZE_RESET;
    end else if (cfg_wr && paddr == ADDR_GROUP_SIZE) begin
      group_size <= pwdata[GSIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_GROUP_SIZE) begin
      prdata = PDATA_W'(group_size);
    end
  end

  // effective group size: zero acts as one, large values clip to the buffer depth
  always_comb begin
    k_eff = KW'(group_size);
    if (group_size == '0) begin
      k_eff = KW'(1);
    end else if (KW'(group_size) > KW'(MAX_GROUP)) begin
      k_eff = KW'(MAX_GROUP);
    end
  end

  // ---------------------------------------------------------------------------
  // collect side
  // ---------------------------------------------------------------------------
  assign elem_acc   = elem_valid & elem_ready;
  assign res_acc    = res_valid & res_ready;
  // count after this item is stored; fill never reaches MAX_GROUP between items
  assign n          = fill + CW'(1);
  assign flush_full = KW'(n) >= k_eff;
  assign flush      = flush_full | elem.last;

  // ---------------------------------------------------------------------------
  // drain sequencing
  // ---------------------------------------------------------------------------
  assign last_res = (rem == CW'(1));
  assign idx_step = rev ? (idx - AW'(1)) : (idx + AW'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (elem_acc && flush) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (res_acc && last_res) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and memory read control
  always_comb begin
    elem_ready = 1'b0;
    res_valid  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx;
    unique case (state)
      ST_IDLE: begin
        elem_ready = 1'b1;
      end
      ST_FETCH: begin
        // first entry of the group; it was written in an earlier cycle
        rd_en = 1'b1;
      end
      ST_SHOW: begin
        res_valid = 1'b1;
        // fetch the following entry as the current one is taken
        if (res_acc && !last_res) begin
          rd_en   = 1'b1;
          rd_addr = idx_step;
        end
      end
      default: begin
        elem_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (elem_acc) begin
        fill <= flush ? '0 : n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (elem_acc && flush) begin
      rem <= n;
      rev <= flush_full;
      lst <= elem.last;
      // full group starts at the newest entry, a short tail at the oldest
      idx <= flush_full ? fill[AW-1:0] : '0;
    end else if (res_acc && !last_res) begin
      rem <= rem - CW'(1);
      idx <= idx_step;
    end
  end

  // group buffer: writes only while collecting and reads only while draining,
  // so the state machine keeps the two ports apart
  always_ff @(posedge clk) begin
    if (elem_acc) begin
      group_mem[fill[AW-1:0]] <= elem.value;
    end
    if (rd_en) begin
      rd_data <= group_mem[rd_addr];
    end
  end

  // result payload comes straight from the registered read data
  assign res.value_res = rd_data;
  assign res.run_end   = last_res;
  assign res.list_end  = last_res & lst;

endmodule

// File: rtl/kgsr_checker.sv
// port-level checker for the k-group stream reverser, bound to the top level
module kgsr_checker (
  input logic            clk,
  input logic            rst,
  input logic            elem_ready,
  input logic            res_valid,
  input logic            res_ready,
  input kgsr_pkg::res_t  res
);
  import kgsr_pkg::*;

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed or dropped while stalled");

  // no item is taken while a group drains
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(elem_ready && res_valid))
    else $error("input ready while results pending");

  // leaving reset, no result is pending and input is open
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !res_valid && elem_ready)
    else $error("results pending after reset");

  // end of sequence only on the last result of a run
  a_list_run: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.list_end |-> res.run_end)
    else $error("list_end without run_end");

endmodule

bind k_group_stream_reverser kgsr_checker u_kgsr_checker (
  .clk        (clk),
  .rst        (rst),
  .elem_ready (elem_ready),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .res        (res)
);
